// ===== hw/rtl/bfmt_pkg.sv =====
// ----------------------------------------------------------------------------
// bfmt_pkg
// Shared types and constants of the layer correction table.
// ----------------------------------------------------------------------------
package bfmt_pkg;

    localparam int DEF_MAX_ENTRIES = 64;

    // Command codes.
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_OFFER  = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_AREA  = 2'd0;
    localparam logic [1:0] CFG_ROOM  = 2'd1;
    localparam logic [1:0] CFG_CHECK = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Acceptance limits.
    localparam logic [7:0]  MAX_SRC_LAYER = 8'd3;
    localparam logic [7:0]  MAX_DST_LAYER = 8'd4;

    typedef struct packed {
        logic [7:0] area;
        logic [7:0] room;
        logic       check;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  entry_area;
        logic [7:0]  entry_room;
        logic [7:0]  layer;
        logic [7:0]  dest_layer;
        logic [15:0] block_col;
        logic [15:0] block_row;
        logic [15:0] expected_block;
        logic        map_present;
        logic [15:0] map_width;
        logic [15:0] map_height;
        logic [15:0] map_word;
    } t_in_item;

    typedef struct packed {
        logic       stored;
        logic [6:0] entry_count;
        logic       found;
        logic [2:0] found_dest;
    } t_out_item;

    // One held correction: column wrapped to 32, row wrapped to 16.
    typedef struct packed {
        logic [1:0] layer;
        logic [2:0] dest;
        logic [4:0] col;
        logic [3:0] row;
    } t_fix_entry;

endpackage

// ===== hw/rtl/block_fix_match_table.sv =====
// ----------------------------------------------------------------------------
// block_fix_match_table
// Bounded table of per-room layer corrections with clear, offer and lookup.
// ----------------------------------------------------------------------------
// Usage: items arrive on the input channel (i_in_valid / o_in_ready) and each
// one produces exactly one result item on the output channel (o_out_valid /
// i_out_ready). Configuration registers are written through i_cfg_we,
// i_cfg_idx and i_cfg_data; index 3 is ignored. The user must write them only
// while the block is idle; the block itself does not enforce this.
// For clear, offer and no-operation items the result is written to the output
// register at the accepting edge and is offered from the next cycle on, so
// these items can follow one per cycle while the receiver keeps up. A lookup
// walks the held entries through a single compare unit fed by the entry
// memory's registered read port, one entry per cycle, and stops at the first
// match. Its result is registered once a match is found or every held entry
// has been compared, and the input stays closed meanwhile, so no new item is
// taken before a lookup's result is registered.
//
// Reset clears the entry count and restores the registers (area 0, room 0,
// map checking on); the entry memory itself is not cleared since only
// entries below the count are ever read. When the receiver stalls, the
// result holds in the output register; a new item is taken once the
// pending result leaves, in the same cycle if it is being taken.
// ----------------------------------------------------------------------------
module block_fix_match_table
    import bfmt_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    // Count width holds MAX_ENTRIES itself; address width just the depth.
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state        r_state, n_state;
    t_cfg          r_cfg, n_cfg;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic [7:0]    r_q_layer, n_q_layer;
    logic [4:0]    r_q_col, n_q_col;
    logic [3:0]    r_q_row, n_q_row;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;

    logic          w_accept;
    logic          w_full;
    logic          w_offer_ok;
    logic          w_we;
    logic          w_re;
    t_fix_entry    w_wdata;
    t_fix_entry    w_rdata;
    logic          w_hit;

    // The output register is free, or is being emptied this cycle.
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count >= CW'(MAX_ENTRIES));

    bfmt_offer_chk u_chk (
        .i_cfg  (r_cfg),
        .i_item (i_in_data),
        .i_full (w_full),
        .o_ok   (w_offer_ok)
    );

    assign w_we = w_accept && (i_in_data.cmd == CMD_OFFER) && w_offer_ok;

    always_comb begin
        w_wdata.layer = i_in_data.layer[1:0];
        w_wdata.dest  = i_in_data.dest_layer[2:0];
        w_wdata.col   = i_in_data.block_col[4:0];
        w_wdata.row   = i_in_data.block_row[3:0];
    end

    // A read is issued while the scan still has entries to visit.
    assign w_re = (r_state == ST_SCAN) && (r_idx < r_count) && !w_hit;

    bfmt_fix_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // The shared compare unit: the entry read last cycle against the query.
    // The held layer is zero-extended so that all eight bits are compared.
    assign w_hit = r_pend &&
                   ({6'd0, w_rdata.layer} == r_q_layer) &&
                   (w_rdata.col == r_q_col) &&
                   (w_rdata.row == r_q_row);

    // Count reported in seven bits, whatever the count width is.
    function automatic logic [6:0] count7(input logic [CW-1:0] c);
        logic [CW+6:0] ext;
        ext = {7'd0, c};
        return ext[6:0];
    endfunction

    always_comb begin
        n_state     = r_state;
        n_cfg       = r_cfg;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_q_layer   = r_q_layer;
        n_q_col     = r_q_col;
        n_q_row     = r_q_row;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_AREA:  n_cfg.area  = i_cfg_data;
                CFG_ROOM:  n_cfg.room  = i_cfg_data;
                CFG_CHECK: n_cfg.check = i_cfg_data[0];
                default:   ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out.stored     = 1'b0;
                    n_out.found      = 1'b0;
                    n_out.found_dest = 3'd0;
                    case (i_in_data.cmd)
                        CMD_CLEAR: begin
                            n_count           = '0;
                            n_out.entry_count = 7'd0;
                            n_out_valid       = 1'b1;
                        end
                        CMD_OFFER: begin
                            if (w_offer_ok) begin
                                n_count      = r_count + CW'(1);
                                n_out.stored = 1'b1;
                            end
                            n_out.entry_count = count7(n_count);
                            n_out_valid       = 1'b1;
                        end
                        CMD_LOOKUP: begin
                            n_q_layer = i_in_data.layer;
                            n_q_col   = i_in_data.block_col[4:0];
                            n_q_row   = i_in_data.block_row[3:0];
                            n_idx     = '0;
                            n_pend    = 1'b0;
                            n_state   = ST_SCAN;
                        end
                        default: begin
                            n_out.entry_count = count7(r_count);
                            n_out_valid       = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (w_hit) begin
                    n_out.stored      = 1'b0;
                    n_out.found       = 1'b1;
                    n_out.found_dest  = w_rdata.dest;
                    n_out.entry_count = count7(r_count);
                    n_out_valid       = 1'b1;
                    n_pend            = 1'b0;
                    n_state           = ST_IDLE;
                end else if (w_re) begin
                    n_idx  = r_idx + CW'(1);
                    n_pend = 1'b1;
                end else begin
                    // Every held entry has been compared without a match.
                    n_out.stored      = 1'b0;
                    n_out.found       = 1'b0;
                    n_out.found_dest  = 3'd0;
                    n_out.entry_count = count7(r_count);
                    n_out_valid       = 1'b1;
                    n_pend            = 1'b0;
                    n_state           = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg.area  <= 8'd0;
            r_cfg.room  <= 8'd0;
            r_cfg.check <= 1'b1;
            r_count     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cfg       <= n_cfg;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_q_layer <= n_q_layer;
        r_q_col   <= n_q_col;
        r_q_row   <= n_q_row;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The table never holds more than its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count beyond table depth");

    // Items other than a lookup finish in the cycle they are taken.
    a_short_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_data.cmd != CMD_LOOKUP)) |=> o_out_valid)
        else $error("single-cycle command gave no result");

    // The scan index never runs past the held count.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= r_count))
        else $error("scan index past entry count");

    // A lookup result never reports a stored offer, and a hit has a legal layer.
    a_found_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.found) |->
            (!o_out_data.stored && (o_out_data.found_dest <= 3'd4)))
        else $error("malformed lookup result");

    // A scan read is only outstanding while scanning.
    a_pend_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == ST_SCAN))
        else $error("read pending outside a scan");

endmodule

// ===== hw/rtl/bfmt_offer_chk.sv =====
// ----------------------------------------------------------------------------
// bfmt_offer_chk
// Acceptance tests for an offered correction, including the map checks.
// ----------------------------------------------------------------------------
module bfmt_offer_chk
    import bfmt_pkg::*;
(
    input  t_cfg     i_cfg,
    input  t_in_item i_item,
    input  logic     i_full,
    output logic     o_ok
);

    logic w_base_ok;
    logic w_map_ok;

    assign w_base_ok = (i_item.entry_area == i_cfg.area) &&
                       (i_item.entry_room == i_cfg.room) &&
                       (i_item.layer <= MAX_SRC_LAYER) &&
                       (i_item.dest_layer <= MAX_DST_LAYER) &&
                       !i_full;

    // An empty map fails the bounds tests by itself.
    assign w_map_ok = i_item.map_present &&
                      (i_item.block_col < i_item.map_width) &&
                      (i_item.block_row < i_item.map_height) &&
                      (i_item.map_word == i_item.expected_block);

    assign o_ok = w_base_ok && (!i_cfg.check || w_map_ok);

endmodule

// ===== hw/rtl/bfmt_fix_mem.sv =====
// ----------------------------------------------------------------------------
// bfmt_fix_mem
// Storage for held corrections: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfmt_fix_mem
    import bfmt_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_ENTRIES,
    parameter int AW    = 6
)
(
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_fix_entry    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_fix_entry    o_rdata
);

    t_fix_entry r_mem [DEPTH];
    t_fix_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the layer correction table.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the correction table and of the three
// configuration registers. Every item taken by the block is run through that
// copy, and the result it gives is queued. Each result item that leaves the
// block is compared field by field with the oldest queued result. A short
// directed part covers the edges of every acceptance test. Several random
// phases follow, each with its own register settings and its own amount of
// sender idling and receiver stalling. A final phase holds the receiver off
// for a long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import bfmt_pkg::*;

    localparam int TABLE_DEPTH = DEF_MAX_ENTRIES;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 300;
    // Worst correct run is about 1400 items; the limit leaves a wide margin.
    localparam longint LIMIT_NS = 64'd6_000_000;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports. Every input has a known value at time 0.
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_AREA;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;

    block_fix_match_table #(
        .MAX_ENTRIES (TABLE_DEPTH)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial forever #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Bench copy of the block state. The registers are updated only while
    // the block is idle, so the copy never runs ahead of the hardware.
    // ------------------------------------------------------------------------
    t_fix_entry  held_fix [TABLE_DEPTH];
    int unsigned held_count = 0;
    logic [7:0]  want_area  = 8'd0;
    logic [7:0]  want_room  = 8'd0;
    logic        map_check  = 1'b1;

    // Items waiting to be offered, and results waiting to come out.
    t_in_item    cmd_backlog [$];
    t_out_item   due_results [$];
    t_out_item   head_result;
    // Positions of recent well-formed offers, so lookups can aim at them.
    t_fix_entry  recent_fix [$];

    int unsigned items_pushed  = 0;
    int unsigned items_taken   = 0;
    int unsigned err_count     = 0;
    int unsigned snd_idle_pct  = 0;
    int unsigned rcv_stall_pct = 0;
    int unsigned hold_seq      = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_cnt      = 0;
    logic        in_fire       = 1'b0;

    // Work out the result of one item and update the bench copy of the table.
    function automatic t_out_item table_response(input t_in_item it);
        t_out_item r;
        bit        ok;
        r = '0;
        case (it.cmd)
            CMD_CLEAR: begin
                held_count = 0;
            end
            CMD_OFFER: begin
                ok = it.entry_area == want_area && it.entry_room == want_room &&
                     it.layer <= MAX_SRC_LAYER && it.dest_layer <= MAX_DST_LAYER &&
                     held_count < TABLE_DEPTH;
                if (map_check) begin
                    ok = ok && it.map_present && it.block_col < it.map_width &&
                         it.block_row < it.map_height && it.map_word == it.expected_block;
                end
                if (ok) begin
                    held_fix[held_count] = '{layer: it.layer[1:0], dest: it.dest_layer[2:0],
                                             col: it.block_col[4:0], row: it.block_row[3:0]};
                    held_count++;
                    r.stored = 1'b1;
                end
            end
            CMD_LOOKUP: begin
                // The lowest matching index wins; the whole 8-bit layer counts.
                for (int i = 0; i < held_count; i++) begin
                    if (!r.found && {6'b0, held_fix[i].layer} == it.layer &&
                        held_fix[i].col == it.block_col[4:0] &&
                        held_fix[i].row == it.block_row[3:0]) begin
                        r.found      = 1'b1;
                        r.found_dest = held_fix[i].dest;
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = 7'(held_count);
        return r;
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver. Inputs change on the falling edge. A new item goes out only
    // when the channel is empty or the previous item was taken at the last
    // rising edge, so valid and payload hold steady until acceptance.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (!in_valid || in_fire) begin
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= cmd_backlog.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver. A new hold request (hold_seq moving on) keeps ready low until
    // hold_cnt, loaded from HOLD_CYCLES, runs out; otherwise ready stalls at random.
    always @(negedge clk) begin
        if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_cnt  <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt  <= hold_cnt - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= $urandom_range(0, 99) >= rcv_stall_pct;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Both channels are sampled on the rising edge. The result is
    // checked before the item taken at the same edge is predicted, since a
    // result can never belong to an item taken in the same cycle.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        in_fire <= rst_n && in_valid && in_ready;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (due_results.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, out_data);
                end else begin
                    head_result = due_results.pop_front();
                    check_field("stored", head_result.stored, out_data.stored);
                    check_field("entry_count", head_result.entry_count, out_data.entry_count);
                    check_field("found", head_result.found, out_data.found);
                    check_field("found_dest", head_result.found_dest, out_data.found_dest);
                end
            end
            if (in_valid && in_ready) begin
                due_results.push_back(table_response(in_data));
                items_taken++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Item builders.
    // ------------------------------------------------------------------------
    function automatic t_in_item noise_item();
        t_in_item it;
        it.cmd            = 2'($urandom);
        it.entry_area     = 8'($urandom);
        it.entry_room     = 8'($urandom);
        it.layer          = 8'($urandom);
        it.dest_layer     = 8'($urandom);
        it.block_col      = 16'($urandom);
        it.block_row      = 16'($urandom);
        it.expected_block = 16'($urandom);
        it.map_present    = 1'($urandom);
        it.map_width      = 16'($urandom);
        it.map_height     = 16'($urandom);
        it.map_word       = 16'($urandom);
        return it;
    endfunction

    // An offer that passes every test with the largest possible map.
    function automatic t_in_item base_offer(input logic [7:0] lyr, input logic [7:0] dst,
                                            input logic [15:0] col, input logic [15:0] row);
        t_in_item it;
        it             = noise_item();
        it.cmd         = CMD_OFFER;
        it.entry_area  = want_area;
        it.entry_room  = want_room;
        it.layer       = lyr;
        it.dest_layer  = dst;
        it.block_col   = col;
        it.block_row   = row;
        it.map_present = 1'b1;
        it.map_width   = 16'hFFFF;
        it.map_height  = 16'hFFFF;
        it.map_word    = it.expected_block;
        return it;
    endfunction

    function automatic t_in_item lookup_at(input logic [7:0] lyr, input logic [15:0] col,
                                           input logic [15:0] row);
        t_in_item it;
        it           = noise_item();
        it.cmd       = CMD_LOOKUP;
        it.layer     = lyr;
        it.block_col = col;
        it.block_row = row;
        return it;
    endfunction

    // Well-formed offer with random content; now and then one test is broken.
    function automatic t_in_item good_offer(input bit may_break);
        t_in_item    it;
        logic [15:0] col;
        logic [15:0] row;
        if ($urandom_range(0, 1) != 0) begin
            col = 16'($urandom_range(0, 63));
            row = 16'($urandom_range(0, 31));
        end else begin
            col = 16'($urandom_range(0, 65534));
            row = 16'($urandom_range(0, 65534));
        end
        it = base_offer(8'($urandom_range(0, 3)), 8'($urandom_range(0, 4)), col, row);
        if ($urandom_range(0, 9) == 0) begin
            it.map_width  = col + 16'd1;
            it.map_height = row + 16'd1;
        end else begin
            it.map_width  = 16'($urandom_range(col + 1, 65535));
            it.map_height = 16'($urandom_range(row + 1, 65535));
        end
        if (may_break && $urandom_range(0, 99) < 15) begin
            case ($urandom_range(0, 7))
                0: it.entry_area  = want_area ^ 8'($urandom_range(1, 255));
                1: it.entry_room  = want_room ^ 8'($urandom_range(1, 255));
                2: it.layer       = 8'($urandom_range(4, 255));
                3: it.dest_layer  = 8'($urandom_range(5, 255));
                4: it.map_present = 1'b0;
                5: it.map_width   = 16'($urandom_range(0, col));
                6: it.map_height  = 16'($urandom_range(0, row));
                default: it.map_word = it.expected_block ^ 16'($urandom_range(1, 65535));
            endcase
        end else begin
            recent_fix.push_back('{layer: it.layer[1:0], dest: it.dest_layer[2:0],
                                   col: col[4:0], row: row[3:0]});
            if (recent_fix.size() > TABLE_DEPTH)
                void'(recent_fix.pop_front());
        end
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item    it;
        t_fix_entry  hit;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            it     = noise_item();
            it.cmd = CMD_CLEAR;
        end else if (pick < 55) begin
            it = good_offer(1'b1);
        end else if (pick < 85) begin
            if (recent_fix.size() != 0 && $urandom_range(0, 99) < 65) begin
                // Aim at a known position; the bits above the wrap are random.
                hit = recent_fix[$urandom_range(0, recent_fix.size() - 1)];
                it  = lookup_at({6'b0, hit.layer}, {11'($urandom), hit.col},
                                {12'($urandom), hit.row});
            end else begin
                it = lookup_at(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0, 4)),
                               16'($urandom_range(0, 63)), 16'($urandom_range(0, 31)));
            end
        end else if (pick < 90) begin
            it     = noise_item();
            it.cmd = CMD_NOP;
        end else begin
            it = noise_item();
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Sequencing helpers. Items are queued right after a rising edge and the
    // registers change on falling edges, so nothing races with the driver.
    // ------------------------------------------------------------------------
    task automatic queue_item(input t_in_item it);
        cmd_backlog.push_back(it);
        items_pushed++;
    endtask

    // Wait until every queued item was taken and every result came out.
    task automatic wait_drained();
        do @(negedge clk);
        while (items_taken != items_pushed || due_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_AREA:  want_area = val;
            CFG_ROOM:  want_room = val;
            CFG_CHECK: map_check = val[0];
            default: ;
        endcase
    endtask

    task automatic set_phase(input logic [7:0] area, input logic [7:0] room,
                             input logic chk, input int unsigned idle,
                             input int unsigned stall);
        write_reg(CFG_AREA, area);
        write_reg(CFG_ROOM, room);
        write_reg(CFG_CHECK, {7'b0, chk});
        @(posedge clk);
        snd_idle_pct  = idle;
        rcv_stall_pct = stall;
    endtask

    // Random phase in two halves; the sender pauses in between until every
    // expected result has come.
    task automatic random_phase(input int unsigned n);
        repeat (n / 2) queue_item(random_item());
        wait_drained();
        @(posedge clk);
        repeat (n - n / 2) queue_item(random_item());
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin
        t_in_item it;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: the edges of every acceptance test.
        set_phase(8'h5A, 8'hC3, 1'b1, 0, 0);
        it = noise_item(); it.cmd = CMD_NOP; queue_item(it);
        queue_item(lookup_at(8'd0, 16'd0, 16'd0));
        // Smallest map that holds the position, smallest fields.
        it = base_offer(8'd0, 8'd0, 16'd0, 16'd0);
        it.map_width = 16'd1; it.map_height = 16'd1;
        it.expected_block = 16'h0000; it.map_word = 16'h0000;
        queue_item(it);
        // Largest accepted layer, destination and position.
        it = base_offer(MAX_SRC_LAYER, MAX_DST_LAYER, 16'hFFFE, 16'hFFFE);
        it.expected_block = 16'hFFFF; it.map_word = 16'hFFFF;
        queue_item(it);
        // One failing test at a time.
        queue_item(base_offer(MAX_SRC_LAYER + 8'd1, 8'd2, 16'd100, 16'd50));
        queue_item(base_offer(8'd1, MAX_DST_LAYER + 8'd1, 16'd100, 16'd50));
        it = base_offer(8'd1, 8'd2, 16'd100, 16'd50); it.entry_area = 8'hA5; queue_item(it);
        it = base_offer(8'd1, 8'd2, 16'd100, 16'd50); it.entry_room = 8'h3C; queue_item(it);
        it = base_offer(8'd1, 8'd2, 16'd100, 16'd50); it.map_present = 1'b0; queue_item(it);
        it = base_offer(8'd1, 8'd2, 16'd100, 16'd50); it.map_width = 16'd100; queue_item(it);
        it = base_offer(8'd1, 8'd2, 16'd100, 16'd50); it.map_height = 16'd50; queue_item(it);
        // An empty map refuses everything while map checking is on.
        it = base_offer(8'd1, 8'd2, 16'd0, 16'd0); it.map_width = 16'd0; queue_item(it);
        it = base_offer(8'd1, 8'd2, 16'd0, 16'd0); it.map_height = 16'd0; queue_item(it);
        it = base_offer(8'd1, 8'd2, 16'd100, 16'd50);
        it.map_word = ~it.expected_block;
        queue_item(it);
        // Lookups through the wrap, and a layer that matches only in its low bits.
        queue_item(lookup_at(8'd0, 16'd32, 16'd16));
        queue_item(lookup_at(8'd3, 16'hFFFE, 16'hFFFE));
        queue_item(lookup_at(8'h83, 16'hFFFE, 16'hFFFE));
        // A second entry at the same wrapped position; the first one wins.
        queue_item(base_offer(8'd0, 8'd2, 16'd64, 16'd48));
        queue_item(lookup_at(8'd0, 16'd0, 16'd0));
        it = noise_item(); it.cmd = CMD_CLEAR; queue_item(it);
        queue_item(lookup_at(8'd0, 16'd0, 16'd0));
        it = noise_item(); it.cmd = CMD_NOP; queue_item(it);
        wait_drained();

        // With map checking off the map fields no longer matter.
        write_reg(CFG_CHECK, 8'd0);
        @(posedge clk);
        it = base_offer(8'd2, 8'd3, 16'hFFFF, 16'hFFFF);
        it.map_present = 1'b0; it.map_width = 16'd0; it.map_height = 16'd0;
        it.map_word = ~it.expected_block;
        queue_item(it);
        queue_item(lookup_at(8'd2, 16'h001F, 16'h000F));
        wait_drained();

        // Random phases across register extremes and idling patterns.
        set_phase(8'h00, 8'h00, 1'b1, 0, 0);
        random_phase(PHASE_ITEMS);
        set_phase(8'hFF, 8'hFF, 1'b0, 71, 0);
        random_phase(PHASE_ITEMS);
        set_phase(8'h37, 8'h81, 1'b1, 0, 71);
        random_phase(PHASE_ITEMS);
        set_phase(8'hFF, 8'h00, 1'b0, 24, 24);
        random_phase(PHASE_ITEMS);

        // Back-pressure: the receiver holds off while the sender keeps
        // offering. The offers also fill the table past its limit.
        set_phase(8'h12, 8'hFE, 1'b1, 0, 0);
        hold_seq++;
        it = noise_item(); it.cmd = CMD_CLEAR; queue_item(it);
        repeat (TABLE_DEPTH + 16) queue_item(good_offer(1'b0));
        repeat (20) queue_item(random_item());
        wait_drained();

        // Wait on after the drain so that a stray extra result is still caught.
        repeat (TABLE_DEPTH + 8) @(negedge clk);
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(LIMIT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
